// ----- sv/slf_pkg.sv -----
`timescale 1ns / 1ps

package slf_pkg;

  // Width of the fade length register and of the fraction of the gain factor.
  localparam int LEN_BITS  = 24;
  localparam int FRAC_BITS = 24;
  // Gain factor is unsigned Q1.24: one integer bit above the fraction.
  localparam int FACT_BITS = FRAC_BITS + 1;
  localparam logic [FACT_BITS-1:0] UNITY = FACT_BITS'(1) << FRAC_BITS;

  // One quotient bit is resolved per divider cycle.
  localparam int DIV_STEPS = FRAC_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH    = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ----- sv/slf_in_if.sv -----
`timescale 1ns / 1ps

interface slf_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          restart;
  logic                          block_end;

  modport source (output valid, output left_sample, output right_sample,
                  output restart, output block_end, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input restart, input block_end, output ready);
endinterface

// ----- sv/slf_out_if.sv -----
`timescale 1ns / 1ps

interface slf_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_scaled;
  logic signed [SAMPLE_BITS-1:0] right_scaled;
  logic                          block_end_out;

  modport source (output valid, output left_scaled, output right_scaled,
                  output block_end_out, input ready);
  modport sink (input valid, input left_scaled, input right_scaled,
                input block_end_out, output ready);
endinterface

// ----- sv/slf_ctrl.sv -----
`timescale 1ns / 1ps

module slf_ctrl import slf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The finished beat waits here until the output register is free.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.mul, cmd.load_out}))
    else $error("more than one datapath command at once");
  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && status.div_last) |=> cmd.mul)
    else $error("multiply did not follow the last divider step");
  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cmd.div_step && !in_ready))
    else $error("accepted beat did not start the divider");
`endif

endmodule

// ----- sv/slf_dp.sv -----
`timescale 1ns / 1ps

module slf_dp import slf_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [LEN_BITS-1:0]           cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  logic                          in_restart,
  input  logic                          in_block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_scaled,
  output logic signed [SAMPLE_BITS-1:0] out_right_scaled,
  output logic                          out_block_end_out
);

  localparam int CMP_W  = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam int PROD_W = SAMPLE_BITS + FACT_BITS + 1;

  // Configuration.
  logic                dir_in_r;
  logic [LEN_BITS-1:0] len_r;

  // Frame state and captured beat.
  logic [COUNT_BITS-1:0]         cnt_r;
  logic                          active_r;
  logic signed [SAMPLE_BITS-1:0] left_r;
  logic signed [SAMPLE_BITS-1:0] right_r;
  logic                          block_end_r;

  // Restoring divider.
  logic [LEN_BITS-1:0]  rem_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [STEP_BITS-1:0] step_r;

  // Products and output register.
  logic signed [PROD_W-1:0]      prod_l_r;
  logic signed [PROD_W-1:0]      prod_r_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;
  logic                          out_block_end_r;

  logic [COUNT_BITS-1:0]       cnt_eff;
  logic [CMP_W-1:0]            cnt_eff_ext;
  logic [CMP_W-1:0]            cnt_ext;
  logic [CMP_W-1:0]            len_ext;
  logic [LEN_BITS:0]           rem_sh;
  logic                        rem_ge;
  logic [LEN_BITS:0]           rem_diff;
  logic [FACT_BITS-1:0]        factor;
  logic signed [FACT_BITS:0]   factor_s;
  logic signed [PROD_W-1:0]    prod_l_nxt;
  logic signed [PROD_W-1:0]    prod_r_nxt;

  // The restart flag clears the counter before this frame is scaled.
  assign cnt_eff     = in_restart ? '0 : cnt_r;
  assign cnt_eff_ext = CMP_W'(cnt_eff);
  assign cnt_ext     = CMP_W'(cnt_r);
  assign len_ext     = CMP_W'(len_r);

  assign rem_sh   = {rem_r, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, len_r};
  assign rem_diff = rem_sh - {1'b0, len_r};

  always_comb begin
    if (active_r) begin
      factor = dir_in_r ? {1'b0, quo_r} : (UNITY - {1'b0, quo_r});
    end else begin
      factor = dir_in_r ? UNITY : '0;
    end
  end

  assign factor_s   = {1'b0, factor};
  assign prod_l_nxt = left_r * factor_s;
  assign prod_r_nxt = right_r * factor_s;

  assign status.div_last = (step_r == STEP_BITS'(DIV_STEPS - 1));
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_in_r <= 1'b1;
      len_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: dir_in_r <= cfg_wdata[0];
        CFG_LENGTH:    len_r    <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= cnt_eff;
    end else if (cmd.mul && active_r && (cnt_r != '1)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r      <= in_left_sample;
      right_r     <= in_right_sample;
      block_end_r <= in_block_end;
      active_r    <= cnt_eff_ext < len_ext;
      // The counter is below the length whenever the quotient is used,
      // so its low bits are the whole starting remainder.
      rem_r       <= cnt_eff_ext[LEN_BITS-1:0];
      quo_r       <= '0;
      step_r      <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_diff[LEN_BITS-1:0] : rem_sh[LEN_BITS-1:0];
      quo_r  <= {quo_r[FRAC_BITS-2:0], rem_ge};
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l_r <= prod_l_nxt;
      prod_r_r <= prod_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Taking the bits above the fraction is an arithmetic shift with floor.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_left_r      <= prod_l_r[FRAC_BITS +: SAMPLE_BITS];
      out_right_r     <= prod_r_r[FRAC_BITS +: SAMPLE_BITS];
      out_block_end_r <= block_end_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_scaled   = out_left_r;
  assign out_right_scaled  = out_right_r;
  assign out_block_end_out = out_block_end_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while its beat is pending");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul && active_r) |=> (cnt_ext <= $past(len_ext)))
    else $error("frame counter stepped past the fade length");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul && !active_r) |=> $stable(cnt_r))
    else $error("frame counter moved after the ramp ended");
`endif

endmodule

// ----- sv/stereo_linear_fade_core.sv -----
`timescale 1ns / 1ps

// Linear fade-in / fade-out on stereo frames.
// in_frame carries one frame per beat: left and right samples (signed Q1.23),
// a restart flag that clears the frame counter before the frame is scaled,
// and a block_end mark that is passed through to out_frame.
// out_frame carries the two scaled samples and the block_end copy.
// cfg_we/cfg_index/cfg_wdata write the direction (index 0, 1 = fade in)
// and the fade length in frames (index 1); write them only while idle.
// From acceptance to a valid output beat, each frame passes through the
// one-bit-per-cycle restoring divider that forms the gain, a multiply
// and the load of the output register.
// A new frame is taken the cycle after the previous one enters the output
// register, so no frame is accepted while another is being computed.
// If the receiver stalls, the finished beat waits in the output register
// while the next frame is computed; that frame then holds until it is free.
// Synchronous reset clears the frame counter, sets fade in with length zero
// and empties the output register.
module stereo_linear_fade_core import slf_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  slf_in_if.sink                  in_frame,
  slf_out_if.source               out_frame,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LEN_BITS-1:0]     cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_frame.ready = in_ready;

  slf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_frame.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  slf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_left_sample    (in_frame.left_sample),
    .in_right_sample   (in_frame.right_sample),
    .in_restart        (in_frame.restart),
    .in_block_end      (in_frame.block_end),
    .out_valid         (out_frame.valid),
    .out_ready         (out_frame.ready),
    .out_left_scaled   (out_frame.left_scaled),
    .out_right_scaled  (out_frame.right_scaled),
    .out_block_end_out (out_frame.block_end_out)
  );

endmodule
